/* hw/rtl/format_char_stream_dec_hex_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the format character stream unit
// Concurrent assertion wrappers, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FORMAT_CHAR_STREAM_DEC_HEX_UNIT_DEFINES_SVH
`define FORMAT_CHAR_STREAM_DEC_HEX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FCSD_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("fcsd assertion failed");
`define FCSD_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("fcsd assertion failed");
`else
`define FCSD_ASSERT(lbl, cond)
`define FCSD_ASSERT_IMPL(lbl, pre, post)
`endif

`endif

/* hw/rtl/fcsd_pkg.sv */
// ----------------------------------------------------------------------------
// Format character stream package
// Shared types, character codes and conversion helpers.
// ----------------------------------------------------------------------------
package fcsd_pkg;

    localparam int FCSD_QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_NUL     = 8'h00;
    localparam logic [7:0] ASCII_PERCENT = 8'h25;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;
    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_D = 8'h64;
    localparam logic [7:0] ASCII_LOWER_S = 8'h73;
    localparam logic [7:0] ASCII_LOWER_X = 8'h78;

    localparam logic [3:0] DEC_UNITS_IDX = 4'd9;
    localparam logic [3:0] HEX_LAST_IDX  = 4'd7;

    typedef enum logic [1:0] {
        KIND_ECHO,
        KIND_DEC,
        KIND_HEX
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  chr;
        logic        neg;
        logic [31:0] mag;
    } t_cmd;

    function automatic logic [33:0] fcsd_weight(logic [3:0] idx, logic [3:0] k);
        logic [33:0] scale;
        logic [37:0] prod;
        unique case (idx)
            4'd0:    scale = 34'd1000000000;
            4'd1:    scale = 34'd100000000;
            4'd2:    scale = 34'd10000000;
            4'd3:    scale = 34'd1000000;
            4'd4:    scale = 34'd100000;
            4'd5:    scale = 34'd10000;
            4'd6:    scale = 34'd1000;
            4'd7:    scale = 34'd100;
            4'd8:    scale = 34'd10;
            default: scale = 34'd0;
        endcase
        prod = 38'(scale) * 38'(k);
        return prod[33:0];
    endfunction

    function automatic logic [7:0] fcsd_hex_char(logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = ASCII_ZERO + {4'b0, nib};
        end else begin
            c = ASCII_LOWER_A + {4'b0, nib - 4'd10};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/fcsd_front.sv */
// ----------------------------------------------------------------------------
// Format character stream front end
// Tracks the pending percent flag and emits echo, dec and hex commands.
// ----------------------------------------------------------------------------
module fcsd_front
    import fcsd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_fmt_char,
    input  logic signed [31:0] i_arg_value,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic r_pending;
    logic n_pending;
    logic w_emit;
    logic [31:0] w_raw;

    assign w_raw = i_arg_value;

    always_comb begin
        n_pending  = r_pending;
        w_emit     = 1'b0;
        o_cmd.kind = KIND_ECHO;
        o_cmd.chr  = i_fmt_char;
        o_cmd.neg  = w_raw[31];
        o_cmd.mag  = w_raw[31] ? (32'd0 - w_raw) : w_raw;
        if (i_fmt_char != ASCII_NUL) begin
            if (r_pending) begin
                if (i_fmt_char == ASCII_LOWER_D) begin
                    n_pending  = 1'b0;
                    w_emit     = 1'b1;
                    o_cmd.kind = KIND_DEC;
                end else if (i_fmt_char == ASCII_LOWER_X) begin
                    n_pending  = 1'b0;
                    w_emit     = 1'b1;
                    o_cmd.kind = KIND_HEX;
                    o_cmd.neg  = 1'b0;
                    o_cmd.mag  = w_raw;
                end else if (i_fmt_char == ASCII_LOWER_S) begin
                    n_pending = 1'b0;
                end
            end else if (i_fmt_char == ASCII_PERCENT) begin
                n_pending = 1'b1;
            end else begin
                w_emit = 1'b1;
            end
        end
    end

    assign o_push = i_accept && w_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else if (i_accept) begin
            r_pending <= n_pending;
        end
    end

endmodule

/* hw/rtl/fcsd_queue.sv */
// ----------------------------------------------------------------------------
// Format character stream command queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module fcsd_queue
    import fcsd_pkg::*;
#(
    parameter int DEPTH = FCSD_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/fcsd_back.sv */
// ----------------------------------------------------------------------------
// Format character stream back end
// Expands commands into an output register, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module fcsd_back
    import fcsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_of_run
);

    logic        r_active;
    t_kind       r_kind;
    logic        r_neg;
    logic [31:0] r_mag;
    logic [3:0]  r_idx;
    logic        r_started;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;

    t_kind       w_kind;
    logic [7:0]  w_chr;
    logic        w_neg;
    logic [31:0] w_mag;
    logic [3:0]  w_idx;
    logic        w_started;

    logic [7:0]  n_chr;
    logic        n_last;
    logic        n_neg;
    logic [31:0] n_mag;
    logic [3:0]  n_idx;
    logic        n_started;

    logic [3:0]  w_digit;
    logic [33:0] w_sub;
    logic        w_can_load;
    logic        w_fire;
    logic        w_use_head;

    assign w_use_head = !r_active;
    assign w_can_load = !r_out_valid || i_out_ready;
    assign w_fire     = (r_active || i_q_valid) && w_can_load;
    assign o_q_pop    = w_fire && w_use_head;

    always_comb begin
        if (w_use_head) begin
            w_kind    = i_q_cmd.kind;
            w_chr     = i_q_cmd.chr;
            w_neg     = i_q_cmd.neg;
            w_mag     = i_q_cmd.mag;
            w_idx     = 4'd0;
            w_started = 1'b0;
        end else begin
            w_kind    = r_kind;
            w_chr     = 8'd0;
            w_neg     = r_neg;
            w_mag     = r_mag;
            w_idx     = r_idx;
            w_started = r_started;
        end
    end

    always_comb begin
        w_digit = 4'd0;
        w_sub   = 34'd0;
        for (int k = 1; k < 10; k++) begin
            if ({2'b00, w_mag} >= fcsd_weight(w_idx, 4'(k))) begin
                w_digit = 4'(k);
                w_sub   = fcsd_weight(w_idx, 4'(k));
            end
        end
    end

    always_comb begin
        n_chr     = w_chr;
        n_last    = 1'b1;
        n_neg     = 1'b0;
        n_mag     = w_mag;
        n_idx     = w_idx;
        n_started = w_started;
        unique case (w_kind)
            KIND_ECHO: begin
                n_chr  = w_chr;
                n_last = 1'b1;
            end
            KIND_DEC: begin
                if (w_neg) begin
                    n_chr  = ASCII_MINUS;
                    n_last = 1'b0;
                end else if (w_idx == DEC_UNITS_IDX) begin
                    n_chr  = ASCII_ZERO + {4'b0, w_mag[3:0]};
                    n_last = 1'b1;
                end else begin
                    n_last = 1'b0;
                    n_idx  = w_idx + 4'd1;
                    n_mag  = w_mag - w_sub[31:0];
                    if (w_digit != 4'd0 || w_started) begin
                        n_chr     = ASCII_ZERO + {4'b0, w_digit};
                        n_started = 1'b1;
                    end else begin
                        n_chr = ASCII_SPACE;
                    end
                end
            end
            KIND_HEX: begin
                n_chr  = fcsd_hex_char(w_mag[31:28]);
                n_last = (w_idx == HEX_LAST_IDX);
                n_mag  = {w_mag[27:0], 4'h0};
                n_idx  = w_idx + 4'd1;
            end
            default: begin
                n_chr  = w_chr;
                n_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_can_load) begin
                r_out_valid <= r_active || i_q_valid;
            end
            if (w_fire) begin
                r_active <= !n_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_char <= n_chr;
            r_out_last <= n_last;
            r_kind     <= w_kind;
            r_neg      <= n_neg;
            r_mag      <= n_mag;
            r_idx      <= n_idx;
            r_started  <= n_started;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_char    = r_out_char;
    assign o_last_of_run = r_out_last;

endmodule

/* hw/rtl/format_char_stream_dec_hex_unit.sv */
// ----------------------------------------------------------------------------
// Format character stream unit, decimal and hex
// The input channel takes one format character and one argument per
// transaction. A plain character is echoed, a percent sign arms a conversion,
// and after it 'd' prints a right-aligned signed decimal of 10 or 11
// characters, 'x' prints eight lowercase hex digits and 's' prints nothing.
// The output channel carries one character per transaction, and
// o_last_of_run marks the final character caused by an input transaction.
// The first character passes through the command queue and then the back
// end's output register. The back end writes one character per cycle into
// its output register while the receiver does not stall it.
// A two-entry command queue sits between the front end and the back end, so
// new input is taken while a conversion is still being printed.
// When the receiver stalls, the output register holds its character and the
// queue fills, after which o_in_ready goes low.
// Reset clears the pending percent flag, the queue and the output valid.
// ----------------------------------------------------------------------------
`include "format_char_stream_dec_hex_unit_defines.svh"

module format_char_stream_dec_hex_unit
    import fcsd_pkg::*;
#(
    parameter int QUEUE_DEPTH = FCSD_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_fmt_char,
    input  logic signed [31:0] i_arg_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_out_char,
    output logic               o_last_of_run
);

    logic w_accept;
    logic w_push;
    t_cmd w_push_cmd;
    logic w_q_ready;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    assign o_in_ready = w_q_ready;
    assign w_accept   = i_in_valid && w_q_ready;

    fcsd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_fmt_char  (i_fmt_char),
        .i_arg_value (i_arg_value),
        .o_push      (w_push),
        .o_cmd       (w_push_cmd)
    );

    fcsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    fcsd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_char    (o_out_char),
        .o_last_of_run (o_last_of_run)
    );

    `FCSD_ASSERT_IMPL(a_full_not_empty, !w_q_ready, w_q_valid)
    `FCSD_ASSERT_IMPL(a_no_nul_out, o_out_valid, o_out_char != ASCII_NUL)
    `FCSD_ASSERT_IMPL(a_out_hold, $past(o_out_valid && !i_out_ready), o_out_valid && $stable(o_out_char) && $stable(o_last_of_run))

endmodule
